// File: rtl/gbd_pkg.sv
// types, constants and classification functions for the grapheme boundary detector
`timescale 1ns / 1ps
`default_nettype none

package gbd_pkg;

    localparam int OFFSET_BITS = 24;
    localparam int CP_BITS     = 21;
    localparam int LEN_BITS    = 3;

    localparam logic [CP_BITS-1:0] CP_LF       = 21'h00000A;
    localparam logic [CP_BITS-1:0] CP_CR       = 21'h00000D;
    localparam logic [CP_BITS-1:0] CP_ZWJ      = 21'h00200D;
    localparam logic [CP_BITS-1:0] CP_RI_LO    = 21'h01F1E6;
    localparam logic [CP_BITS-1:0] CP_RI_HI    = 21'h01F1FF;
    localparam logic [CP_BITS-1:0] CP_SKIN_LO  = 21'h01F3FB;
    localparam logic [CP_BITS-1:0] CP_SKIN_HI  = 21'h01F3FF;
    localparam logic [CP_BITS-1:0] CP_VS_LO    = 21'h00FE00;
    localparam logic [CP_BITS-1:0] CP_VS_HI    = 21'h00FE0F;
    localparam logic [CP_BITS-1:0] CP_JAMO_L   = 21'h001100;
    localparam logic [CP_BITS-1:0] CP_JAMO_V   = 21'h001160;
    localparam logic [CP_BITS-1:0] CP_JAMO_T   = 21'h0011A8;
    localparam logic [CP_BITS-1:0] CP_JAMO_END = 21'h0011FF;
    localparam logic [CP_BITS-1:0] CP_EMOJI_LO = 21'h01F300;
    localparam logic [CP_BITS-1:0] CP_EMOJI_HI = 21'h01FAFF;

    localparam logic [LEN_BITS-1:0] LEN_MIN = 3'd1;
    localparam logic [LEN_BITS-1:0] LEN_MAX = 3'd4;

    typedef struct packed {
        logic [CP_BITS-1:0]  code_point;
        logic [LEN_BITS-1:0] seq_bytes;
        logic                text_start;
        logic                text_end;
    } t_item;

    typedef struct packed {
        logic [OFFSET_BITS-1:0] boundary_offset;
        logic                   is_text_end;
        logic                   run_last;
    } t_result;

    typedef struct packed {
        logic [CP_BITS-1:0]     prev_cp;
        logic                   prev_regional;
        logic                   run_odd;
        logic [OFFSET_BITS-1:0] byte_pos;
    } t_state;

    // up to two result words produced by one item
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_res_pair;

    function automatic logic f_in_rng(input logic [CP_BITS-1:0] c,
                                      input logic [CP_BITS-1:0] lo,
                                      input logic [CP_BITS-1:0] hi);
        return (c >= lo) && (c <= hi);
    endfunction

    function automatic logic f_combining(input logic [CP_BITS-1:0] c);
        return f_in_rng(c, 21'h0300, 21'h036F) || f_in_rng(c, 21'h0483, 21'h0489) ||
               f_in_rng(c, 21'h0591, 21'h05BD) || (c == 21'h05BF) || (c == 21'h05C1) ||
               (c == 21'h05C2) || f_in_rng(c, 21'h05C4, 21'h05C5) || (c == 21'h05C7) ||
               f_in_rng(c, 21'h0610, 21'h061A) || f_in_rng(c, 21'h064B, 21'h065F) ||
               (c == 21'h0670) || f_in_rng(c, 21'h06D6, 21'h06DC) ||
               f_in_rng(c, 21'h06DF, 21'h06E4) || f_in_rng(c, 21'h06E7, 21'h06E8) ||
               f_in_rng(c, 21'h06EA, 21'h06ED) || (c == 21'h0711) ||
               f_in_rng(c, 21'h0730, 21'h074A) || f_in_rng(c, 21'h07A6, 21'h07B0) ||
               f_in_rng(c, 21'h07EB, 21'h07F3) || f_in_rng(c, 21'h0816, 21'h0819) ||
               f_in_rng(c, 21'h081B, 21'h0823) || f_in_rng(c, 21'h0825, 21'h0827) ||
               f_in_rng(c, 21'h0829, 21'h082D) || f_in_rng(c, 21'h0859, 21'h085B) ||
               f_in_rng(c, 21'h0E31, 21'h0E3A) || f_in_rng(c, 21'h0EB1, 21'h0EBC) ||
               f_in_rng(c, 21'h0F71, 21'h0F84) || f_in_rng(c, 21'h1AB0, 21'h1AFF) ||
               f_in_rng(c, 21'h1DC0, 21'h1DFF) || f_in_rng(c, 21'h20D0, 21'h20F0) ||
               (c == 21'h3099) || (c == 21'h309A) || f_in_rng(c, 21'hFE20, 21'hFE2F);
    endfunction

    function automatic logic f_var_selector(input logic [CP_BITS-1:0] c);
        return f_in_rng(c, CP_VS_LO, CP_VS_HI) || f_in_rng(c, 21'h180B, 21'h180D);
    endfunction

    function automatic logic f_regional(input logic [CP_BITS-1:0] c);
        return f_in_rng(c, CP_RI_LO, CP_RI_HI);
    endfunction

    function automatic logic f_emoji_base(input logic [CP_BITS-1:0] c);
        return f_in_rng(c, CP_EMOJI_LO, CP_EMOJI_HI) || f_in_rng(c, 21'h2600, 21'h27BF) ||
               (c == 21'h231A) || (c == 21'h231B) || (c == CP_ZWJ);
    endfunction

endpackage

`default_nettype wire

// File: rtl/gbd_if.sv
// valid/ready channel interfaces for code point input and boundary output
`timescale 1ns / 1ps
`default_nettype none

interface gbd_in_if;
    logic        valid;
    logic        ready;
    logic [20:0] code_point;
    logic [2:0]  seq_bytes;
    logic        text_start;
    logic        text_end;

    modport source (output valid, output code_point, output seq_bytes,
                    output text_start, output text_end, input ready);
    modport sink   (input valid, input code_point, input seq_bytes,
                    input text_start, input text_end, output ready);
endinterface

interface gbd_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] boundary_offset;
    logic        is_text_end;
    logic        run_last;

    modport source (output valid, output boundary_offset, output is_text_end,
                    output run_last, input ready);
    modport sink   (input valid, input boundary_offset, input is_text_end,
                    input run_last, output ready);
endinterface

`default_nettype wire

// File: rtl/gbd_eval.sv
// boundary rules, result words and next state for one code point
`timescale 1ns / 1ps
`default_nettype none

module gbd_eval
    import gbd_pkg::*;
(
    input  wire t_item     i_item,
    input  wire t_state    i_state,
    output t_res_pair      o_res,
    output t_state         o_state
);

    logic [CP_BITS-1:0]     cp;
    logic [CP_BITS-1:0]     prev;
    logic [LEN_BITS-1:0]    len;
    logic                   cur_ri;
    logic                   joined;
    logic                   first_hit;
    logic [OFFSET_BITS-1:0] base;
    logic [OFFSET_BITS:0]   sum;
    logic [OFFSET_BITS-1:0] pos_next;
    logic                   odd_cleared;
    t_result                first_res;
    t_result                end_res;

    assign cp     = i_item.code_point;
    assign prev   = i_state.prev_cp;
    assign cur_ri = f_regional(cp);

    always_comb begin
        if (i_item.seq_bytes < LEN_MIN) begin
            len = LEN_MIN;
        end else if (i_item.seq_bytes > LEN_MAX) begin
            len = LEN_MAX;
        end else begin
            len = i_item.seq_bytes;
        end
    end

    always_comb begin
        joined = 1'b0;
        if ((prev == CP_CR) && (cp == CP_LF)) joined = 1'b1;
        if (f_combining(cp) || f_var_selector(cp)) joined = 1'b1;
        if (f_in_rng(cp, CP_SKIN_LO, CP_SKIN_HI) && f_emoji_base(prev)) joined = 1'b1;
        if ((cp == CP_ZWJ) || (prev == CP_ZWJ)) joined = 1'b1;
        // second indicator of a pair
        if (cur_ri && i_state.prev_regional && i_state.run_odd) joined = 1'b1;
        if (f_in_rng(cp, CP_JAMO_V, CP_JAMO_T - 21'd1) &&
            f_in_rng(prev, CP_JAMO_L, CP_JAMO_T - 21'd1)) joined = 1'b1;
        if (f_in_rng(cp, CP_JAMO_T, CP_JAMO_END) &&
            f_in_rng(prev, CP_JAMO_V, CP_JAMO_END)) joined = 1'b1;
    end

    assign first_hit   = i_item.text_start || !joined;
    assign odd_cleared = first_hit ? 1'b0 : i_state.run_odd;

    // saturating byte counter
    assign base = i_item.text_start ? '0 : i_state.byte_pos;
    assign sum  = {1'b0, base} + {{(OFFSET_BITS + 1 - LEN_BITS){1'b0}}, len};
    assign pos_next = sum[OFFSET_BITS] ? '1 : sum[OFFSET_BITS-1:0];

    always_comb begin
        first_res.boundary_offset = base;
        first_res.is_text_end     = 1'b0;
        first_res.run_last        = !i_item.text_end;
        end_res.boundary_offset   = pos_next;
        end_res.is_text_end       = 1'b1;
        end_res.run_last          = 1'b1;

        o_res.count = {1'b0, first_hit} + {1'b0, i_item.text_end};
        o_res.res1  = end_res;
        o_res.res0  = first_hit ? first_res : end_res;
    end

    always_comb begin
        o_state.prev_cp       = cp;
        o_state.prev_regional = cur_ri;
        o_state.run_odd       = odd_cleared ^ cur_ri;
        o_state.byte_pos      = pos_next;
    end

endmodule

`default_nettype wire

// File: rtl/gbd_res_queue.sv
// two-word result queue that drains one boundary word per cycle while the output is ready
`timescale 1ns / 1ps
`default_nettype none

module gbd_res_queue
    import gbd_pkg::*;
(
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_load,
    input  wire t_res_pair i_res,
    output logic           o_can_load,
    gbd_out_if.source      o_out
);

    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    t_result    r_q0;
    t_result    r_q1;
    t_result    n_q0;
    t_result    n_q1;
    logic       pop;

    assign pop        = (r_cnt != 2'd0) && o_out.ready;
    assign o_can_load = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && pop);

    always_comb begin
        n_cnt = r_cnt;
        n_q0  = r_q0;
        n_q1  = r_q1;
        if (i_load) begin
            // queue is empty after this edge's pop, so overwrite
            n_cnt = i_res.count;
            n_q0  = i_res.res0;
            n_q1  = i_res.res1;
        end else if (pop) begin
            n_cnt = r_cnt - 2'd1;
            n_q0  = r_q1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

    assign o_out.valid           = (r_cnt != 2'd0);
    assign o_out.boundary_offset = r_q0.boundary_offset;
    assign o_out.is_text_end     = r_q0.is_text_end;
    assign o_out.run_last        = r_q0.run_last;

endmodule

`default_nettype wire

// File: rtl/grapheme_boundary_detector_core.sv
// Grapheme cluster boundary detector: takes one decoded code point per word with its
// UTF-8 length and start/end-of-text marks, and emits byte offsets of cluster
// boundaries (offset 0 at text start, the text length after the last code point).
// One code point is accepted every cycle while the queue has room, and is held in the
// input register. The rule logic then writes its 0, 1 or 2 result words into a
// two-word output queue, and the first result is presented from the queue register.
// The queue drains one word a cycle while the output is ready, so an item that causes
// two results holds the input side until its last word is being taken. A stalled
// output fills the queue and then the input register, after which the input stalls.
// The byte offset saturates at its top value.
`timescale 1ns / 1ps
`default_nettype none

module grapheme_boundary_detector_core
    import gbd_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    gbd_in_if.sink    i_in,
    gbd_out_if.source o_out
);

    logic      r_in_valid;
    t_item     r_item;
    t_state    r_state;
    t_state    n_state;
    t_res_pair res;
    logic      can_load;
    logic      advance;

    assign advance    = r_in_valid && can_load;
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= '0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_state <= n_state;
            end
        end
        if (i_in.ready && i_in.valid) begin
            r_item.code_point <= i_in.code_point;
            r_item.seq_bytes  <= i_in.seq_bytes;
            r_item.text_start <= i_in.text_start;
            r_item.text_end   <= i_in.text_end;
        end
    end

    gbd_eval u_eval (
        .i_item  (r_item),
        .i_state (r_state),
        .o_res   (res),
        .o_state (n_state)
    );

    gbd_res_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (advance),
        .i_res      (res),
        .o_can_load (can_load),
        .o_out      (o_out)
    );

endmodule

`default_nettype wire

// File: rtl/gbd_checker.sv
// port-level checks for the grapheme boundary detector, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module gbd_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_in_valid,
    input wire        i_in_ready,
    input wire        i_in_text_start,
    input wire        i_out_valid,
    input wire        i_out_ready,
    input wire [23:0] i_out_offset,
    input wire        i_out_end,
    input wire        i_out_last
);

    // a stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            ($stable(i_out_offset) && $stable(i_out_end) && $stable(i_out_last)))
        else $error("output word changed while stalled");

    // end-of-text offset always closes its item's results
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_end) |-> i_out_last)
        else $error("end-of-text word not marked last");

    // an accepted text start is always followed by a valid output word
    a_start_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_text_start) |-> ##2 i_out_valid)
        else $error("no boundary word after text start");

endmodule

bind grapheme_boundary_detector_core gbd_checker u_gbd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_in_text_start (i_in.text_start),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_offset    (o_out.boundary_offset),
    .i_out_end       (o_out.is_text_end),
    .i_out_last      (o_out.run_last)
);

`default_nettype wire

// File: tb/sv/tb_grapheme_boundary_detector_core.sv
// self-checking testbench for the grapheme boundary detector core
`timescale 1ns / 1ps

module tb_grapheme_boundary_detector_core;
    import gbd_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n;

    gbd_in_if  in_ch ();
    gbd_out_if out_ch ();

    grapheme_boundary_detector_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // directed row: n < 0 means the offsets come from the software segmenter
    typedef struct {
        int cp;
        int len;
        bit s;
        bit e;
        int n;
        int ofs0;
        bit e0;
        int ofs1;
        bit e1;
    } t_dir_row;

    localparam int DIR_ROWS = 25;

    t_dir_row dir_tab [DIR_ROWS];

    // software segmenter state
    logic [CP_BITS-1:0]     seg_prev_cp;
    logic                   seg_prev_ri;
    logic                   seg_ri_odd;
    logic [OFFSET_BITS-1:0] seg_pos;

    t_result boundary_q [$];

    int err_count   = 0;
    int items_sent  = 0;
    int words_seen  = 0;
    int in_stalls   = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_left   = 0;
    bit hold_req    = 1'b0;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        err_count++;
        $display("mismatch, %0s: got %0d, expected %0d", what, got, want);
    endtask

    function automatic logic in_span(input logic [CP_BITS-1:0] c,
                                     input logic [CP_BITS-1:0] lo,
                                     input logic [CP_BITS-1:0] hi);
        return (c >= lo) && (c <= hi);
    endfunction

    function automatic logic is_ri(input logic [CP_BITS-1:0] c);
        return in_span(c, CP_RI_LO, CP_RI_HI);
    endfunction

    // true when no cluster boundary falls between prev and c
    function automatic logic stays_joined(input logic [CP_BITS-1:0] prev,
                                          input logic [CP_BITS-1:0] c);
        logic mark;
        logic vs;
        logic base;
        mark = in_span(c, 21'h0300, 21'h036F) || in_span(c, 21'h0483, 21'h0489) ||
               in_span(c, 21'h0591, 21'h05BD) || c == 21'h05BF || c == 21'h05C1 ||
               c == 21'h05C2 || in_span(c, 21'h05C4, 21'h05C5) || c == 21'h05C7 ||
               in_span(c, 21'h0610, 21'h061A) || in_span(c, 21'h064B, 21'h065F) ||
               c == 21'h0670 || in_span(c, 21'h06D6, 21'h06DC) ||
               in_span(c, 21'h06DF, 21'h06E4) || in_span(c, 21'h06E7, 21'h06E8) ||
               in_span(c, 21'h06EA, 21'h06ED) || c == 21'h0711 ||
               in_span(c, 21'h0730, 21'h074A) || in_span(c, 21'h07A6, 21'h07B0) ||
               in_span(c, 21'h07EB, 21'h07F3) || in_span(c, 21'h0816, 21'h0819) ||
               in_span(c, 21'h081B, 21'h0823) || in_span(c, 21'h0825, 21'h0827) ||
               in_span(c, 21'h0829, 21'h082D) || in_span(c, 21'h0859, 21'h085B) ||
               in_span(c, 21'h0E31, 21'h0E3A) || in_span(c, 21'h0EB1, 21'h0EBC) ||
               in_span(c, 21'h0F71, 21'h0F84) || in_span(c, 21'h1AB0, 21'h1AFF) ||
               in_span(c, 21'h1DC0, 21'h1DFF) || in_span(c, 21'h20D0, 21'h20F0) ||
               c == 21'h3099 || c == 21'h309A || in_span(c, 21'hFE20, 21'hFE2F);
        vs = in_span(c, CP_VS_LO, CP_VS_HI) || in_span(c, 21'h180B, 21'h180D);
        base = in_span(prev, CP_EMOJI_LO, CP_EMOJI_HI) || in_span(prev, 21'h2600, 21'h27BF) ||
               prev == 21'h231A || prev == 21'h231B || prev == CP_ZWJ;
        return (prev == CP_CR && c == CP_LF) || mark || vs ||
               (in_span(c, CP_SKIN_LO, CP_SKIN_HI) && base) ||
               c == CP_ZWJ || prev == CP_ZWJ ||
               (is_ri(c) && seg_prev_ri && seg_ri_odd) ||
               (in_span(c, CP_JAMO_V, CP_JAMO_T - 21'd1) &&
                in_span(prev, CP_JAMO_L, CP_JAMO_T - 21'd1)) ||
               (in_span(c, CP_JAMO_T, CP_JAMO_END) && in_span(prev, CP_JAMO_V, CP_JAMO_END));
    endfunction

    // advance the segmenter by one code point and return the boundaries it causes
    function automatic t_res_pair segment_step(input t_item it);
        t_res_pair              rp;
        logic [CP_BITS-1:0]     c;
        logic [LEN_BITS-1:0]    nb;
        logic [OFFSET_BITS:0]   sum;
        logic                   cut;
        rp  = '0;
        c   = it.code_point;
        nb  = it.seq_bytes;
        cut = 1'b0;
        if (nb < LEN_MIN) nb = LEN_MIN;
        if (nb > LEN_MAX) nb = LEN_MAX;
        if (it.text_start) begin
            seg_pos    = '0;
            seg_ri_odd = 1'b0;
            cut        = 1'b1;
        end else if (!stays_joined(seg_prev_cp, c)) begin
            cut        = 1'b1;
            seg_ri_odd = 1'b0;
        end
        if (cut) begin
            rp.res0.boundary_offset = seg_pos;
            rp.count = 2'd1;
        end
        if (is_ri(c)) seg_ri_odd = !seg_ri_odd;
        seg_prev_ri = is_ri(c);
        seg_prev_cp = c;
        sum = {1'b0, seg_pos} + {{(OFFSET_BITS + 1 - LEN_BITS){1'b0}}, nb};
        // offset sticks at all ones
        seg_pos = sum[OFFSET_BITS] ? '1 : sum[OFFSET_BITS-1:0];
        if (it.text_end) begin
            if (cut) begin
                rp.res1.boundary_offset = seg_pos;
                rp.res1.is_text_end     = 1'b1;
                rp.count = 2'd2;
            end else begin
                rp.res0.boundary_offset = seg_pos;
                rp.res0.is_text_end     = 1'b1;
                rp.count = 2'd1;
            end
        end
        if (rp.count == 2'd1) rp.res0.run_last = 1'b1;
        if (rp.count == 2'd2) rp.res1.run_last = 1'b1;
        return rp;
    endfunction

    task automatic queue_boundaries(input t_res_pair rp);
        if (rp.count > 0) boundary_q = {boundary_q, rp.res0};
        if (rp.count > 1) boundary_q = {boundary_q, rp.res1};
    endtask

    // present one word, with random idle cycles ahead of it, and wait for acceptance
    task automatic offer_word(input t_item it);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.code_point <= it.code_point;
        in_ch.seq_bytes  <= it.seq_bytes;
        in_ch.text_start <= it.text_start;
        in_ch.text_end   <= it.text_end;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
    endtask

    // random texts built from the interesting code point classes
    task automatic run_phase(input int n_items, input int tx_pct, input int rx_pct);
        int                 done;
        int                 len;
        t_item              it;
        logic [CP_BITS-1:0] c;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        done = 0;
        while (done < n_items) begin
            len = $urandom_range(1, 10);
            for (int k = 0; k < len; k++) begin
                case ($urandom_range(0, 15))
                    0:  c = CP_BITS'($urandom_range(32, 126));
                    1:  c = CP_CR;
                    2:  c = CP_LF;
                    3: begin
                        case ($urandom_range(0, 5))
                            0:       c = CP_BITS'($urandom_range(21'h0300, 21'h036F));
                            1:       c = CP_BITS'($urandom_range(21'h0591, 21'h05BD));
                            2:       c = CP_BITS'($urandom_range(21'h1AB0, 21'h1AFF));
                            3:       c = CP_BITS'($urandom_range(21'h20D0, 21'h20F0));
                            4:       c = CP_BITS'($urandom_range(21'hFE20, 21'hFE2F));
                            default: c = CP_BITS'($urandom_range(21'h0400, 21'h0F90));
                        endcase
                    end
                    4:  c = CP_BITS'($urandom_range(0, 1) ? $urandom_range(CP_VS_LO, CP_VS_HI)
                                                          : $urandom_range(21'h180A, 21'h180E));
                    5:  c = CP_BITS'($urandom_range(CP_SKIN_LO - 1, CP_SKIN_HI + 1));
                    6: begin
                        case ($urandom_range(0, 2))
                            0:       c = CP_BITS'($urandom_range(CP_EMOJI_LO, CP_EMOJI_HI));
                            1:       c = CP_BITS'($urandom_range(21'h2600, 21'h27BF));
                            default: c = CP_BITS'($urandom_range(21'h2319, 21'h231C));
                        endcase
                    end
                    7:  c = CP_ZWJ;
                    8:  c = CP_BITS'($urandom_range(CP_RI_LO, CP_RI_HI));
                    9:  c = CP_BITS'($urandom_range(CP_RI_LO - 1, CP_RI_HI + 1));
                    10: c = CP_BITS'($urandom_range(CP_JAMO_L - 1, CP_JAMO_V - 1));
                    11: c = CP_BITS'($urandom_range(CP_JAMO_V, CP_JAMO_T - 1));
                    12: c = CP_BITS'($urandom_range(CP_JAMO_T, CP_JAMO_END + 1));
                    13: c = CP_BITS'($urandom);
                    14: c = CP_BITS'($urandom_range(21'h110000, 21'h1FFFFF));
                    default: c = CP_BITS'($urandom_range(0, 16'hFFFF));
                endcase
                it.code_point = c;
                if ($urandom_range(7) == 0) begin
                    it.seq_bytes = LEN_BITS'($urandom_range(0, 7));
                end else begin
                    it.seq_bytes = (c < 21'h80) ? 3'd1 : (c < 21'h800) ? 3'd2 :
                                   (c < 21'h10000) ? 3'd3 : 3'd4;
                end
                it.text_start = (k == 0);
                it.text_end   = (k == len - 1);
                // broken framing now and then
                if ($urandom_range(9) == 0) begin
                    it.text_start = 1'($urandom);
                    it.text_end   = 1'($urandom);
                end
                offer_word(it);
                queue_boundaries(segment_step(it));
                done++;
            end
        end
    endtask

    // receiver: random ready, or a long hold-off on request
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = 60;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && !in_ch.ready) in_stalls++;
            if (out_ch.valid && out_ch.ready) begin
                words_seen++;
                if (boundary_q.size() == 0) begin
                    report_mismatch("result word with nothing expected",
                                    out_ch.boundary_offset, -1);
                end else begin
                    if (out_ch.boundary_offset !== boundary_q[0].boundary_offset)
                        report_mismatch("boundary_offset", out_ch.boundary_offset,
                                        boundary_q[0].boundary_offset);
                    if (out_ch.is_text_end !== boundary_q[0].is_text_end)
                        report_mismatch("is_text_end", out_ch.is_text_end,
                                        boundary_q[0].is_text_end);
                    if (out_ch.run_last !== boundary_q[0].run_last)
                        report_mismatch("run_last", out_ch.run_last, boundary_q[0].run_last);
                    void'(boundary_q.pop_front());
                end
            end
        end
    end

    initial begin
        #400000;
        $display("tb_grapheme_boundary_detector_core: done, errors");
        $finish;
    end

    initial begin
        t_item     it;
        t_res_pair rp;

        dir_tab = '{
            // after reset the first word breaks against code point zero
            '{32'h41,           1, 0, 0,  1, 0, 0, 0, 0},
            '{int'(CP_CR),      1, 1, 0,  1, 0, 0, 0, 0},
            '{int'(CP_LF),      1, 0, 0,  0, 0, 0, 0, 0},
            '{32'h0300,         2, 0, 0,  0, 0, 0, 0, 0},
            '{32'h036F,         2, 0, 0,  0, 0, 0, 0, 0},
            '{int'(CP_VS_HI),   3, 0, 0,  0, 0, 0, 0, 0},
            '{32'h1F44D,        4, 0, 0, -1, 0, 0, 0, 0},
            '{int'(CP_SKIN_LO), 4, 0, 0, -1, 0, 0, 0, 0},
            '{int'(CP_ZWJ),     3, 0, 0, -1, 0, 0, 0, 0},
            '{32'h2764,         3, 0, 0, -1, 0, 0, 0, 0},
            '{int'(CP_RI_LO),   4, 0, 0, -1, 0, 0, 0, 0},
            '{int'(CP_RI_HI),   4, 0, 0, -1, 0, 0, 0, 0},
            '{int'(CP_RI_LO),   4, 0, 0, -1, 0, 0, 0, 0},
            '{int'(CP_JAMO_L),  3, 0, 0, -1, 0, 0, 0, 0},
            '{int'(CP_JAMO_V),  3, 0, 0, -1, 0, 0, 0, 0},
            '{int'(CP_JAMO_T),  3, 0, 0, -1, 0, 0, 0, 0},
            '{int'(CP_JAMO_END), 3, 0, 1, -1, 0, 0, 0, 0},
            // one-word texts, byte length clamped high and low
            '{32'h1FFFFF,       7, 1, 1,  2, 0, 0, 4, 1},
            '{32'h0,            0, 1, 1,  2, 0, 0, 1, 1},
            // continues after an end without a new start
            '{32'h10FFFF,       5, 0, 0, -1, 0, 0, 0, 0},
            '{int'(CP_SKIN_HI), 4, 0, 0, -1, 0, 0, 0, 0},
            '{32'h180B,         3, 0, 0, -1, 0, 0, 0, 0},
            '{int'(CP_CR),      1, 0, 0, -1, 0, 0, 0, 0},
            '{int'(CP_LF),      1, 0, 1, -1, 0, 0, 0, 0},
            '{32'h110000,       4, 1, 0, -1, 0, 0, 0, 0}
        };

        i_rst_n          <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.code_point <= '0;
        in_ch.seq_bytes  <= LEN_MIN;
        in_ch.text_start <= 1'b0;
        in_ch.text_end   <= 1'b0;
        seg_prev_cp = '0;
        seg_prev_ri = 1'b0;
        seg_ri_odd  = 1'b0;
        seg_pos     = '0;
        tx_idle_pct = 34;
        rx_idle_pct = 64;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            it.code_point = dir_tab[r].cp[CP_BITS-1:0];
            it.seq_bytes  = dir_tab[r].len[LEN_BITS-1:0];
            it.text_start = dir_tab[r].s;
            it.text_end   = dir_tab[r].e;
            offer_word(it);
            rp = segment_step(it);
            if (dir_tab[r].n >= 0) begin
                rp.count = dir_tab[r].n[1:0];
                rp.res0  = '{dir_tab[r].ofs0[OFFSET_BITS-1:0], dir_tab[r].e0,
                             dir_tab[r].n == 1};
                rp.res1  = '{dir_tab[r].ofs1[OFFSET_BITS-1:0], dir_tab[r].e1, 1'b1};
            end
            queue_boundaries(rp);
        end

        run_phase(200, 34, 64);
        run_phase(200, 64, 34);
        // receiver stalls for a long stretch while words keep coming
        hold_req = 1'b1;
        run_phase(200, 0, 0);

        in_ch.valid <= 1'b0;
        while (boundary_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("covered %0d code point words (directed table and random texts) and %0d",
                 items_sent, words_seen);
        $display("boundary words, %0d input stall cycles, %0d mismatches",
                 in_stalls, err_count);
        if (err_count == 0) begin
            $display("tb_grapheme_boundary_detector_core: done, clean");
        end else begin
            $display("tb_grapheme_boundary_detector_core: done, errors");
        end
        $finish;
    end

endmodule
